// ===== rtl/core/tpos_pkg.sv =====
// Shared types and constants for the two-pulse, one-saw sound generator.
package tpos_pkg;

  localparam int CNT_W   = 17;
  localparam int PER_W   = 12;
  localparam int PCT_W   = 7;
  localparam int OPND_W  = 5;
  localparam int LEVEL_W = 5;
  localparam int SHIFT_W = 4;
  localparam int DIV_W   = 5;
  localparam int SAMPLE_W = 17;

  // Register pages after masking the address with 0xf003.
  localparam logic [3:0] PAGE_P0  = 4'h9;
  localparam logic [3:0] PAGE_P1  = 4'hA;
  localparam logic [3:0] PAGE_SAW = 4'hB;

  // Low address lines within a page.
  localparam logic [1:0] LO_CTRL   = 2'd0;
  localparam logic [1:0] LO_PER_LO = 2'd1;
  localparam logic [1:0] LO_PER_HI = 2'd2;
  localparam logic [1:0] LO_GLOBAL = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SWAP      = 3'd0;
  localparam logic [2:0] CFG_DIVIDER   = 3'd1;
  localparam logic [2:0] CFG_P0_LEVEL  = 3'd2;
  localparam logic [2:0] CFG_P1_LEVEL  = 3'd3;
  localparam logic [2:0] CFG_SAW_LEVEL = 3'd4;

  localparam logic [DIV_W-1:0] DIVIDER_RESET = 5'd12;
  localparam logic [PCT_W-1:0] PCT_MAX       = 7'd100;

  // Division by 100 as a multiply by 5243 and a shift by 19.
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [17:0] MIX_GAIN = 18'd166434;

  localparam logic [3:0] SAW_LAST_PHASE = 4'd13;

  typedef struct packed {
    logic [PER_W-1:0]   period;
    logic [SHIFT_W-1:0] shift;
    logic [DIV_W-1:0]   divider;
    logic [PCT_W-1:0]   pct;
    logic [OPND_W-1:0]  operand;
  } calc_req_t;

endpackage

// ===== rtl/core/two_pulse_one_saw_sound_generator.sv =====
// The shared calc unit serves the three channels in turn, a prep state and an apply state
// for each; then a mix state forms the sum and an output state loads the output register,
// waiting while a held result is stalled. Items are taken only in the idle state.
// A new item is taken while an earlier result still waits in the output register.
// Synchronous active-low reset clears all channel state and restores register defaults.
module two_pulse_one_saw_sound_generator
  import tpos_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [PCT_W-1:0]           cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [15:0]                in_bus_address,
  input  logic [7:0]                 in_write_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_mixed_sample
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_MIX   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [1:0] CH_SAW = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;

  // Configuration.
  logic             swap_r;
  logic [DIV_W-1:0] div_r;
  logic [PCT_W-1:0] p0_pct_r, p1_pct_r, saw_pct_r;

  // Latched item.
  logic       op_r;
  logic [3:0] page_r;
  logic [1:0] lo_r;
  logic [7:0] data_r;
  logic [1:0] lo_in;

  // Channel state.
  logic [CNT_W-1:0] pulse_cnt_r   [2], pulse_cnt_nxt   [2];
  logic [PER_W-1:0] pulse_per_r   [2], pulse_per_nxt   [2];
  logic [2:0]       pulse_duty_r  [2], pulse_duty_nxt  [2];
  logic [3:0]       pulse_phase_r [2], pulse_phase_nxt [2];
  logic [3:0]       pulse_vol_r   [2], pulse_vol_nxt   [2];
  logic             pulse_const_r [2], pulse_const_nxt [2];
  logic             pulse_en_r    [2], pulse_en_nxt    [2];
  logic [3:0]       pulse_level_r [2], pulse_level_nxt [2];

  logic [CNT_W-1:0]   saw_cnt_r,   saw_cnt_nxt;
  logic [PER_W-1:0]   saw_per_r,   saw_per_nxt;
  logic [5:0]         saw_rate_r,  saw_rate_nxt;
  logic [3:0]         saw_phase_r, saw_phase_nxt;
  logic [7:0]         saw_acc_r,   saw_acc_nxt;
  logic               saw_en_r,    saw_en_nxt;
  logic [LEVEL_W-1:0] saw_level_r, saw_level_nxt;
  logic               halted_r,    halted_nxt;
  logic [SHIFT_W-1:0] shift_r,     shift_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [23:0]         mix_r;
  logic [24:0]         mix_round;
  logic [SAMPLE_W-1:0] mix_neg;

  // Shared unit hookup.
  calc_req_t          req;
  logic               calc_en;
  logic [CNT_W-1:0]   reload;
  logic [LEVEL_W-1:0] level_q;

  // Per-channel selection.
  logic               pidx;
  logic               is_saw;
  logic [3:0]         ch_page;
  logic               wr_here;
  logic               do_tick;
  logic [PER_W-1:0]   cur_per;
  logic [PER_W-1:0]   eff_per;
  logic [7:0]         acc_new;
  logic [PCT_W-1:0]   pct_sel;
  logic [PCT_W-1:0]   pct_clamp;
  logic [5:0]         level_sum;
  logic               in_beat;

  assign in_beat  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign lo_in    = swap_r ? {in_bus_address[0], in_bus_address[1]} : in_bus_address[1:0];

  assign pidx    = ch_r[0];
  assign is_saw  = (ch_r == CH_SAW);
  assign ch_page = is_saw ? PAGE_SAW : (pidx ? PAGE_P1 : PAGE_P0);
  assign wr_here = !op_r && (page_r == ch_page);
  assign do_tick = op_r && !halted_r;
  assign cur_per = is_saw ? saw_per_r : pulse_per_r[pidx];
  // An enable write reloads from the period that the same write sets.
  assign eff_per = (wr_here && lo_r == LO_PER_HI) ? {data_r[3:0], cur_per[7:0]} : cur_per;
  assign acc_new = (saw_phase_r == 4'd0) ? 8'd0 : saw_acc_r + {2'b0, saw_rate_r};

  always_comb begin
    case (ch_r)
      2'd0:    pct_sel = p0_pct_r;
      2'd1:    pct_sel = p1_pct_r;
      default: pct_sel = saw_pct_r;
    endcase
  end

  assign pct_clamp = (pct_sel > PCT_MAX) ? PCT_MAX : pct_sel;

  assign req.period  = eff_per;
  assign req.shift   = shift_r;
  assign req.divider = div_r;
  assign req.pct     = pct_clamp;
  assign req.operand = is_saw ? acc_new[7:3] : {1'b0, pulse_vol_r[pidx]};
  assign calc_en     = (state_r == ST_PREP);

  tpos_calc u_calc (
    .clk    (clk),
    .en     (calc_en),
    .req    (req),
    .reload (reload),
    .level  (level_q)
  );

  assign level_sum = {2'b0, pulse_level_r[0]} + {2'b0, pulse_level_r[1]} + {1'b0, saw_level_r};
  assign mix_round = {1'b0, mix_r} + 25'd255;
  assign mix_neg   = SAMPLE_W'(0) - mix_round[24:8];

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    for (int i = 0; i < 2; i++) begin
      pulse_cnt_nxt[i]   = pulse_cnt_r[i];
      pulse_per_nxt[i]   = pulse_per_r[i];
      pulse_duty_nxt[i]  = pulse_duty_r[i];
      pulse_phase_nxt[i] = pulse_phase_r[i];
      pulse_vol_nxt[i]   = pulse_vol_r[i];
      pulse_const_nxt[i] = pulse_const_r[i];
      pulse_en_nxt[i]    = pulse_en_r[i];
      pulse_level_nxt[i] = pulse_level_r[i];
    end
    saw_cnt_nxt   = saw_cnt_r;
    saw_per_nxt   = saw_per_r;
    saw_rate_nxt  = saw_rate_r;
    saw_phase_nxt = saw_phase_r;
    saw_acc_nxt   = saw_acc_r;
    saw_en_nxt    = saw_en_r;
    saw_level_nxt = saw_level_r;
    halted_nxt    = halted_r;
    shift_nxt     = shift_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          ch_nxt    = 2'd0;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (is_saw) begin
          if (wr_here) begin
            case (lo_r)
              LO_CTRL:   saw_rate_nxt = data_r[5:0];
              LO_PER_LO: saw_per_nxt = {saw_per_r[11:8], data_r};
              LO_PER_HI: begin
                saw_per_nxt = {data_r[3:0], saw_per_r[7:0]};
                saw_en_nxt  = data_r[7];
                if (saw_en_r && !data_r[7]) begin
                  saw_phase_nxt = 4'd0;
                  saw_acc_nxt   = 8'd0;
                  saw_level_nxt = '0;
                end
              end
              default: ;
            endcase
          end else if (do_tick && saw_en_r) begin
            if (saw_cnt_r > CNT_W'(1)) begin
              saw_cnt_nxt = saw_cnt_r - CNT_W'(1);
            end else begin
              saw_cnt_nxt = reload;
              if (!saw_phase_r[0]) begin
                saw_acc_nxt   = acc_new;
                saw_level_nxt = level_q;
              end
              saw_phase_nxt = (saw_phase_r >= SAW_LAST_PHASE) ? 4'd0 : saw_phase_r + 4'd1;
            end
          end
          state_nxt = ST_MIX;
        end else begin
          if (wr_here) begin
            case (lo_r)
              LO_CTRL: begin
                pulse_vol_nxt[pidx]   = data_r[3:0];
                pulse_duty_nxt[pidx]  = data_r[6:4];
                pulse_const_nxt[pidx] = data_r[7];
              end
              LO_PER_LO: pulse_per_nxt[pidx] = {pulse_per_r[pidx][11:8], data_r};
              LO_PER_HI: begin
                pulse_per_nxt[pidx] = {data_r[3:0], pulse_per_r[pidx][7:0]};
                pulse_en_nxt[pidx]  = data_r[7];
                if (pulse_en_r[pidx] != data_r[7]) begin
                  if (data_r[7]) begin
                    pulse_cnt_nxt[pidx] = reload;
                  end else begin
                    pulse_phase_nxt[pidx] = 4'd15;
                    pulse_level_nxt[pidx] = 4'd0;
                  end
                end
              end
              default: ;
            endcase
          end else if (do_tick && pulse_en_r[pidx]) begin
            if (pulse_cnt_r[pidx] > CNT_W'(1)) begin
              pulse_cnt_nxt[pidx] = pulse_cnt_r[pidx] - CNT_W'(1);
            end else begin
              pulse_cnt_nxt[pidx] = reload;
              if (pulse_const_r[pidx] || ({1'b0, pulse_duty_r[pidx]} >= pulse_phase_r[pidx]))
              begin
                pulse_level_nxt[pidx] = level_q[3:0];
              end else begin
                pulse_level_nxt[pidx] = 4'd0;
              end
              pulse_phase_nxt[pidx] = pulse_phase_r[pidx] - 4'd1;
            end
          end
          ch_nxt    = ch_r + 2'd1;
          state_nxt = ST_PREP;
        end
      end
      ST_MIX: begin
        // The global register only touches halt and shift, which the channels read earlier.
        if (!op_r && page_r == PAGE_P0 && lo_r == LO_GLOBAL) begin
          halted_nxt = data_r[0];
          shift_nxt  = (data_r[2:1] == 2'd3) ? 4'd8 : {data_r[2:1], 2'b00};
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= 2'd0;
      out_valid_r <= 1'b0;
      swap_r      <= 1'b0;
      div_r       <= DIVIDER_RESET;
      p0_pct_r    <= PCT_MAX;
      p1_pct_r    <= PCT_MAX;
      saw_pct_r   <= PCT_MAX;
      for (int i = 0; i < 2; i++) begin
        pulse_cnt_r[i]   <= '0;
        pulse_per_r[i]   <= '0;
        pulse_duty_r[i]  <= '0;
        pulse_phase_r[i] <= '0;
        pulse_vol_r[i]   <= '0;
        pulse_const_r[i] <= 1'b0;
        pulse_en_r[i]    <= 1'b0;
        pulse_level_r[i] <= '0;
      end
      saw_cnt_r   <= '0;
      saw_per_r   <= '0;
      saw_rate_r  <= '0;
      saw_phase_r <= '0;
      saw_acc_r   <= '0;
      saw_en_r    <= 1'b0;
      saw_level_r <= '0;
      halted_r    <= 1'b0;
      shift_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SWAP:      swap_r    <= cfg_wdata[0];
          CFG_DIVIDER:   div_r     <= cfg_wdata[DIV_W-1:0];
          CFG_P0_LEVEL:  p0_pct_r  <= cfg_wdata;
          CFG_P1_LEVEL:  p1_pct_r  <= cfg_wdata;
          CFG_SAW_LEVEL: saw_pct_r <= cfg_wdata;
          default: ;
        endcase
      end
      for (int i = 0; i < 2; i++) begin
        pulse_cnt_r[i]   <= pulse_cnt_nxt[i];
        pulse_per_r[i]   <= pulse_per_nxt[i];
        pulse_duty_r[i]  <= pulse_duty_nxt[i];
        pulse_phase_r[i] <= pulse_phase_nxt[i];
        pulse_vol_r[i]   <= pulse_vol_nxt[i];
        pulse_const_r[i] <= pulse_const_nxt[i];
        pulse_en_r[i]    <= pulse_en_nxt[i];
        pulse_level_r[i] <= pulse_level_nxt[i];
      end
      saw_cnt_r   <= saw_cnt_nxt;
      saw_per_r   <= saw_per_nxt;
      saw_rate_r  <= saw_rate_nxt;
      saw_phase_r <= saw_phase_nxt;
      saw_acc_r   <= saw_acc_nxt;
      saw_en_r    <= saw_en_nxt;
      saw_level_r <= saw_level_nxt;
      halted_r    <= halted_nxt;
      shift_r     <= shift_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r   <= in_op;
      page_r <= in_bus_address[15:12];
      lo_r   <= lo_in;
      data_r <= in_write_data;
    end
    if (state_r == ST_MIX) begin
      mix_r <= {18'b0, level_sum} * {6'b0, MIX_GAIN};
    end
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_sample_r <= mix_neg;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_sample_r;

`ifndef SYNTHESIS
  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result beat raised outside the output state");

  a_pulse0_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !pulse_en_r[0] |-> pulse_level_r[0] == 4'd0)
    else $error("disabled first pulse channel holds a level");

  a_pulse1_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !pulse_en_r[1] |-> pulse_level_r[1] == 4'd0)
    else $error("disabled second pulse channel holds a level");

  a_saw_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !saw_en_r |-> (saw_level_r == '0 && saw_acc_r == 8'd0 && saw_phase_r == 4'd0))
    else $error("disabled saw channel holds state");
`endif

endmodule

// ===== rtl/core/tpos_calc.sv =====
// Shared arithmetic unit: reload count and percent-scaled channel level.
module tpos_calc
  import tpos_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  calc_req_t          req,
  output logic [CNT_W-1:0]   reload,
  output logic [LEVEL_W-1:0] level
);

  logic [PER_W:0]   base;
  logic [17:0]      reload_full;
  logic [11:0]      scaled;
  logic [CNT_W-1:0] reload_r;
  logic [11:0]      prod_r;
  logic [24:0]      quot;

  assign base        = (PER_W+1)'(req.period >> req.shift) + (PER_W+1)'(1);
  assign reload_full = {5'b0, base} * {13'b0, req.divider};
  assign scaled      = {5'b0, req.pct} * {7'b0, req.operand};

  // Registered step: reload and the product before division.
  always_ff @(posedge clk) begin
    if (en) begin
      reload_r <= reload_full[CNT_W-1:0];
      prod_r   <= scaled;
    end
  end

  // Combinational step after the register: divide the registered product by 100.
  assign quot   = {13'b0, prod_r} * {12'b0, DIV100_RECIP};
  assign reload = reload_r;
  assign level  = quot[DIV100_SHIFT+LEVEL_W-1:DIV100_SHIFT];

endmodule

// ===== dv/tb_two_pulse_one_saw_sound_generator.sv =====
// Self-checking testbench for the sound generator: bus writes and ticks in, samples out.
`timescale 1ns / 100ps

module tb_two_pulse_one_saw_sound_generator
  import tpos_pkg::*;
;

  localparam bit OP_WRITE = 1'b0;
  localparam bit OP_TICK  = 1'b1;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_PRINTED     = 40;

  // Tracks the sound state the block should hold and the samples it still owes.
  class tone_scoreboard;
    bit                         addr_swap;
    logic [DIV_W-1:0]           divider;
    logic [PCT_W-1:0]           pulse_pct [2];
    logic [PCT_W-1:0]           saw_pct;
    logic [CNT_W-1:0]           pulse_count [2];
    logic [PER_W-1:0]           pulse_per [2];
    logic [2:0]                 pulse_duty [2];
    logic [3:0]                 pulse_phase [2];
    logic [3:0]                 pulse_vol [2];
    bit                         pulse_const [2];
    bit                         pulse_on [2];
    logic [3:0]                 pulse_lvl [2];
    logic [CNT_W-1:0]           saw_count;
    logic [PER_W-1:0]           saw_per;
    logic [5:0]                 saw_rate;
    logic [3:0]                 saw_phase;
    logic [7:0]                 saw_acc;
    bit                         saw_on;
    logic [LEVEL_W-1:0]         saw_lvl;
    bit                         halted;
    logic [SHIFT_W-1:0]         shift;
    logic signed [SAMPLE_W-1:0] samples_due [$];
    int                         ticks_seen;
    int                         writes_seen;
    int                         pulse_steps;
    int                         saw_steps;

    function new();
      int ch;
      addr_swap = 1'b0;
      divider = DIVIDER_RESET;
      saw_pct = PCT_MAX;
      for (ch = 0; ch < 2; ch++) begin
        pulse_pct[ch] = PCT_MAX;
        pulse_count[ch] = '0;
        pulse_per[ch] = '0;
        pulse_duty[ch] = '0;
        pulse_phase[ch] = '0;
        pulse_vol[ch] = '0;
        pulse_const[ch] = 1'b0;
        pulse_on[ch] = 1'b0;
        pulse_lvl[ch] = '0;
      end
      saw_count = '0;
      saw_per = '0;
      saw_rate = '0;
      saw_phase = '0;
      saw_acc = '0;
      saw_on = 1'b0;
      saw_lvl = '0;
      halted = 1'b0;
      shift = '0;
      ticks_seen = 0;
      writes_seen = 0;
      pulse_steps = 0;
      saw_steps = 0;
    endfunction

    function void set_register(input logic [2:0] idx, input logic [PCT_W-1:0] val);
      case (idx)
        CFG_SWAP:      addr_swap = val[0];
        CFG_DIVIDER:   divider = val[DIV_W-1:0];
        CFG_P0_LEVEL:  pulse_pct[0] = val;
        CFG_P1_LEVEL:  pulse_pct[1] = val;
        CFG_SAW_LEVEL: saw_pct = val;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_pct(input logic [PCT_W-1:0] p);
      return (p > PCT_MAX) ? 32'(PCT_MAX) : 32'(p);
    endfunction

    function logic [CNT_W-1:0] reload_for(input logic [PER_W-1:0] per);
      int unsigned r;
      r = ((int'(per) >> shift) + 1) * divider;
      return r[CNT_W-1:0];
    endfunction

    function void step_pulse(input int ch);
      int unsigned lvl;
      if (pulse_count[ch] > 1) begin
        pulse_count[ch] = pulse_count[ch] - 1'b1;
        return;
      end
      pulse_steps++;
      pulse_count[ch] = reload_for(pulse_per[ch]);
      if (pulse_const[ch] || pulse_phase[ch] <= pulse_duty[ch])
        lvl = clamp_pct(pulse_pct[ch]) * pulse_vol[ch] / 100;
      else
        lvl = 0;
      pulse_lvl[ch] = lvl[3:0];
      pulse_phase[ch] = pulse_phase[ch] - 4'd1;
    endfunction

    function void step_saw();
      int unsigned lvl;
      if (saw_count > 1) begin
        saw_count = saw_count - 1'b1;
        return;
      end
      saw_steps++;
      saw_count = reload_for(saw_per);
      // The accumulator only moves on even phases; phase zero restarts the ramp.
      if (!saw_phase[0]) begin
        if (saw_phase == 4'd0)
          saw_acc = 8'd0;
        else
          saw_acc = saw_acc + saw_rate;
        lvl = int'(saw_acc >> 3) * clamp_pct(saw_pct) / 100;
        saw_lvl = lvl[LEVEL_W-1:0];
      end
      saw_phase = (saw_phase >= SAW_LAST_PHASE) ? 4'd0 : saw_phase + 4'd1;
    endfunction

    function void bus_write(input logic [15:0] addr, input logic [7:0] d);
      logic [3:0] page;
      logic [1:0] lo;
      int         ch;
      bit         turn_on;
      // Masking with 0xf003 leaves only the page nibble and the two low lines.
      page = addr[15:12];
      lo = addr[1:0];
      if (addr_swap)
        lo = {lo[0], lo[1]};
      if (page == PAGE_P0 || page == PAGE_P1) begin
        ch = (page == PAGE_P1) ? 1 : 0;
        case (lo)
          LO_CTRL: begin
            pulse_vol[ch] = d[3:0];
            pulse_duty[ch] = d[6:4];
            pulse_const[ch] = d[7];
          end
          LO_PER_LO: pulse_per[ch][7:0] = d;
          LO_PER_HI: begin
            pulse_per[ch][11:8] = d[3:0];
            turn_on = d[7];
            if (turn_on != pulse_on[ch]) begin
              if (turn_on) begin
                pulse_count[ch] = reload_for(pulse_per[ch]);
              end else begin
                pulse_phase[ch] = 4'hF;
                pulse_lvl[ch] = 4'd0;
              end
              pulse_on[ch] = turn_on;
            end
          end
          default: begin
            if (ch == 0) begin
              halted = d[0];
              shift = (d[2:1] == 2'd3) ? 4'd8 : {d[2:1], 2'b00};
            end
          end
        endcase
      end else if (page == PAGE_SAW) begin
        case (lo)
          LO_CTRL:   saw_rate = d[5:0];
          LO_PER_LO: saw_per[7:0] = d;
          LO_PER_HI: begin
            saw_per[11:8] = d[3:0];
            turn_on = d[7];
            if (turn_on != saw_on && !turn_on) begin
              saw_phase = 4'd0;
              saw_lvl = '0;
              saw_acc = 8'd0;
            end
            saw_on = turn_on;
          end
          default: ;
        endcase
      end
    endfunction

    function void note_item(input bit op, input logic [15:0] addr, input logic [7:0] data);
      int unsigned                sum;
      int unsigned                mag;
      int                         neg;
      logic signed [SAMPLE_W-1:0] want;
      if (op == OP_WRITE) begin
        writes_seen++;
        bus_write(addr, data);
      end else begin
        ticks_seen++;
        if (!halted) begin
          if (pulse_on[0])
            step_pulse(0);
          if (pulse_on[1])
            step_pulse(1);
          if (saw_on)
            step_saw();
        end
      end
      sum = pulse_lvl[0] + pulse_lvl[1] + saw_lvl;
      mag = (sum * MIX_GAIN + 255) >> 8;
      neg = -int'(mag);
      want = neg[SAMPLE_W-1:0];
      samples_due.push_back(want);
    endfunction

    function bit check_sample(input logic signed [SAMPLE_W-1:0] got, output bit had_one,
                              output logic signed [SAMPLE_W-1:0] want);
      had_one = (samples_due.size() != 0);
      want = '0;
      if (!had_one)
        return 1'b0;
      want = samples_due.pop_front();
      return (got === want);
    endfunction

    function int pending();
      return samples_due.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [2:0]                 cfg_index = CFG_SWAP;
  logic [PCT_W-1:0]           cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_op = OP_TICK;
  logic [15:0]                in_bus_address = '0;
  logic [7:0]                 in_write_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_mixed_sample;

  tone_scoreboard sb;
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit cur_swap = 1'b0;

  two_pulse_one_saw_sound_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_bus_address   (in_bus_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mixed_sample (out_mixed_sample)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL two_pulse_one_saw_sound_generator");
      $finish;
    end
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("ERROR: %s", msg);
  endtask

  // Output side: check every sample beat and stall at random.
  always @(posedge clk) begin
    bit                         had_one;
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (!sb.check_sample(out_mixed_sample, had_one, want)) begin
        if (!had_one)
          report($sformatf("sample %0d arrived with none expected", out_mixed_sample));
        else
          report($sformatf("sample %0d, expected %0d", out_mixed_sample, want));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [15:0] reg_addr(input logic [3:0] page, input logic [1:0] lo);
    return {page, 10'd0, lo};
  endfunction

  // Returns at the edge that took the beat, so the next call may drive at once.
  task automatic send_item(input bit op, input logic [15:0] addr, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_bus_address <= addr;
    in_write_data <= data;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, addr, data);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input bit swap, input logic [DIV_W-1:0] div,
                                input logic [PCT_W-1:0] p0, input logic [PCT_W-1:0] p1,
                                input logic [PCT_W-1:0] saw);
    logic [2:0]       idx [5];
    logic [PCT_W-1:0] val [5];
    int               k;
    idx = '{CFG_SWAP, CFG_DIVIDER, CFG_P0_LEVEL, CFG_P1_LEVEL, CFG_SAW_LEVEL};
    val = '{{6'd0, swap}, {2'd0, div}, p0, p1, saw};
    for (k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      sb.set_register(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
    cur_swap = swap;
  endtask

  // Mostly ticks and writes to live registers, shaped so the counters expire often.
  task automatic send_random_item();
    int          sel;
    logic [1:0]  reg_lo;
    logic [15:0] addr;
    logic [7:0]  data;
    sel = $urandom_range(99);
    addr = 16'($urandom);
    data = 8'($urandom);
    if (sel < 55) begin
      send_item(OP_TICK, addr, data);
    end else if (sel < 92) begin
      case ($urandom_range(2))
        0: addr[15:12] = PAGE_P0;
        1: addr[15:12] = PAGE_P1;
        default: addr[15:12] = PAGE_SAW;
      endcase
      reg_lo = cur_swap ? {addr[0], addr[1]} : addr[1:0];
      case (reg_lo)
        LO_PER_LO: if ($urandom_range(3) != 0) data = 8'($urandom_range(7));
        LO_PER_HI: begin
          if ($urandom_range(3) != 0) begin
            data[3:0] = 4'd0;
            data[7] = ($urandom_range(5) != 0);
          end
        end
        LO_GLOBAL: data[0] = ($urandom_range(7) == 0);
        default: ;
      endcase
      send_item(OP_WRITE, addr, data);
    end else begin
      send_item(OP_WRITE, addr, data);
    end
  endtask

  initial begin
    int ph;
    int i;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_stall_pct = 79;
    apply_settings(1'b0, 5'd1, PCT_MAX, PCT_MAX, PCT_MAX);

    // Directed opening: every register, halt, every shift code and unmapped writes.
    send_item(OP_TICK, 16'hFFFF, 8'hFF);
    send_item(OP_WRITE, reg_addr(PAGE_P0, LO_CTRL), 8'h8F);
    send_item(OP_WRITE, reg_addr(PAGE_P0, LO_PER_LO), 8'h00);
    send_item(OP_WRITE, reg_addr(PAGE_P0, LO_PER_HI), 8'h80);
    send_item(OP_TICK, 16'h0000, 8'h00);
    send_item(OP_WRITE, reg_addr(PAGE_P1, LO_CTRL), 8'h7A);
    send_item(OP_WRITE, reg_addr(PAGE_P1, LO_PER_LO), 8'h01);
    send_item(OP_WRITE, reg_addr(PAGE_P1, LO_PER_HI), 8'h80);
    send_item(OP_WRITE, reg_addr(PAGE_SAW, LO_CTRL), 8'h3F);
    send_item(OP_WRITE, reg_addr(PAGE_SAW, LO_PER_LO), 8'h00);
    send_item(OP_WRITE, reg_addr(PAGE_SAW, LO_PER_HI), 8'h80);
    send_item(OP_TICK, 16'h1234, 8'h5A);
    send_item(OP_TICK, 16'hEDCB, 8'hA5);
    send_item(OP_TICK, 16'h0000, 8'hFF);
    // Halt, tick while halted, then release with each nonzero shift code.
    send_item(OP_WRITE, reg_addr(PAGE_P0, LO_GLOBAL), 8'h01);
    send_item(OP_TICK, 16'hFFFF, 8'h00);
    send_item(OP_WRITE, reg_addr(PAGE_P0, LO_GLOBAL), 8'h06);
    send_item(OP_TICK, 16'h0000, 8'h00);
    send_item(OP_WRITE, reg_addr(PAGE_P0, LO_GLOBAL), 8'h04);
    send_item(OP_WRITE, reg_addr(PAGE_P0, LO_GLOBAL), 8'h02);
    // Writes that land on no register.
    send_item(OP_WRITE, reg_addr(PAGE_P1, LO_GLOBAL), 8'hFF);
    send_item(OP_WRITE, reg_addr(PAGE_SAW, LO_GLOBAL), 8'hFF);
    send_item(OP_WRITE, 16'hFFFF, 8'hFF);
    send_item(OP_WRITE, 16'h0000, 8'h00);
    // Turn every channel off again.
    send_item(OP_WRITE, reg_addr(PAGE_P0, LO_PER_HI), 8'h0F);
    send_item(OP_WRITE, reg_addr(PAGE_P1, LO_PER_HI), 8'h00);
    send_item(OP_WRITE, reg_addr(PAGE_SAW, LO_PER_HI), 8'h00);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 14;
        recv_stall_pct = 79;
      end else if (ph < 4) begin
        send_idle_pct = 79;
        recv_stall_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (ph)
        0: apply_settings(1'b1, 5'd2, 7'd100, 7'd50, 7'd75);
        1: apply_settings(1'b0, 5'd31, 7'd0, 7'd100, 7'd100);
        2: apply_settings(1'b1, 5'd0, 7'd127, 7'd101, 7'd0);
        3: apply_settings(1'b0, 5'd3, 7'd37, 7'd99, 7'd127);
        4: apply_settings(1'b1, 5'd1, 7'd100, 7'd100, 7'd100);
        default: apply_settings(1'b0, 5'd12, 7'd63, 7'd1, 7'd88);
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Once, hold the sender until the output side has drained completely.
        if (ph == 1 && i == ITEMS_PER_PHASE / 2)
          settle();
        send_random_item();
      end
      settle();
    end

    $display("Covered %0d items: %0d ticks and %0d bus writes over seven register settings.",
             sb.ticks_seen + sb.writes_seen, sb.ticks_seen, sb.writes_seen);
    $display("Channel steps: %0d pulse, %0d saw; %0d mismatches.",
             sb.pulse_steps, sb.saw_steps, errors);
    if (errors == 0)
      $display("PASS two_pulse_one_saw_sound_generator");
    else
      $display("FAIL two_pulse_one_saw_sound_generator");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tpos_pkg.sv
rtl/core/tpos_calc.sv
rtl/core/two_pulse_one_saw_sound_generator.sv
dv/tb_two_pulse_one_saw_sound_generator.sv
